// ===== src/sle_pkg.sv =====
// shared types and constants for the sequential list engine
`timescale 1ns / 1ps

package sle_pkg;

    localparam int MODE_W  = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int COUNT_W = 9;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND  = 3'd0,
        MODE_SEARCH  = 3'd1,
        MODE_REMOVE  = 3'd2,
        MODE_INSERT  = 3'd3,
        MODE_REM_ALL = 3'd4,
        MODE_CLEAR   = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RM_LAST,
        ST_RA_CMP,
        ST_RA_SWAP,
        ST_INS_SH,
        ST_INS_PUT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               ok;
        logic               found;
        logic [POS_W-1:0]   found_position;
        logic [COUNT_W-1:0] element_count;
    } t_result;

endpackage

// ===== src/sle_store.sv =====
// element memory, one write port and one registered read port
`timescale 1ns / 1ps

module sle_store
    import sle_pkg::*;
#(
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  logic [VALUE_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [ADDR_W-1:0]  i_raddr,
    output logic [VALUE_W-1:0] o_rdata
);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sle_seq.sv =====
// sequencer that walks the element memory for each request
`timescale 1ns / 1ps

module sle_seq
    import sle_pkg::*;
#(
    parameter int CAPACITY = 256,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [POS_W-1:0]   i_pos,
    output logic               o_mem_we,
    output logic [AW-1:0]      o_mem_waddr,
    output logic [VALUE_W-1:0] o_mem_wdata,
    output logic               o_mem_re,
    output logic [AW-1:0]      o_mem_raddr,
    input  logic [VALUE_W-1:0] i_mem_rdata,
    output logic               o_res_valid,
    input  logic               i_res_take,
    output t_result            o_res
);

    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_removed, n_removed;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic [AW-1:0]      r_fpos, n_fpos;
    logic               r_found, n_found;
    logic               r_ok, n_ok;
    t_mode              r_mode, n_mode;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [POS_W-1:0]   r_pos, n_pos;

    logic          match;
    logic          not_full;
    logic [XW-1:0] ra_last;
    logic [XW-1:0] count_m1;

    assign match    = (i_mem_rdata == r_value);
    assign not_full = (XW'(r_count) < XW'(CAPACITY));
    assign count_m1 = XW'(r_count) - XW'(1);
    assign ra_last  = XW'(r_count) - XW'(r_removed) - XW'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_removed   = r_removed;
        n_ptr       = r_ptr;
        n_fpos      = r_fpos;
        n_found     = r_found;
        n_ok        = r_ok;
        n_mode      = r_mode;
        n_value     = r_value;
        n_pos       = r_pos;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;
        o_res_valid = 1'b0;
        o_ready     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_mode    = t_mode'(i_mode);
                    n_value   = i_value;
                    n_pos     = i_pos;
                    n_found   = 1'b0;
                    n_fpos    = '0;
                    n_ok      = 1'b0;
                    n_removed = '0;
                    n_ptr     = '0;
                    n_state   = ST_DONE;
                    unique case (t_mode'(i_mode))
                        MODE_APPEND: begin
                            if (not_full) begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = AW'(r_count);
                                o_mem_wdata = i_value;
                                n_count     = r_count + CW'(1);
                                n_ok        = 1'b1;
                            end
                        end
                        MODE_SEARCH, MODE_REMOVE: begin
                            n_ok = 1'b1;
                            if (r_count != '0) begin
                                o_mem_re = 1'b1;
                                n_state  = ST_SCAN;
                            end
                        end
                        MODE_INSERT: begin
                            if ((XW'(i_pos) < XW'(r_count)) && not_full) begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = AW'(count_m1);
                                n_ptr       = AW'(count_m1);
                                n_state     = ST_INS_SH;
                            end
                        end
                        MODE_REM_ALL: begin
                            n_ok = 1'b1;
                            if (r_count != '0) begin
                                o_mem_re = 1'b1;
                                n_state  = ST_RA_CMP;
                            end
                        end
                        MODE_CLEAR: begin
                            n_count = '0;
                            n_ok    = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // compare one element per cycle while the next read is in flight
            ST_SCAN: begin
                if (match) begin
                    n_found = 1'b1;
                    n_fpos  = r_ptr;
                    if (r_mode == MODE_REMOVE) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = AW'(count_m1);
                        n_state     = ST_RM_LAST;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else if (XW'(r_ptr) + XW'(1) < XW'(r_count)) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_ptr + AW'(1);
                    n_ptr       = r_ptr + AW'(1);
                end else begin
                    n_state = ST_DONE;
                end
            end

            // last element lands in the matched slot
            ST_RM_LAST: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_fpos;
                o_mem_wdata = i_mem_rdata;
                n_count     = r_count - CW'(1);
                n_state     = ST_DONE;
            end

            ST_RA_CMP: begin
                if (match) begin
                    if (!r_found) begin
                        n_found = 1'b1;
                        n_fpos  = r_ptr;
                    end
                    n_removed = r_removed + CW'(1);
                    if (ra_last == XW'(r_ptr)) begin
                        n_count = r_count - r_removed - CW'(1);
                        n_state = ST_DONE;
                    end else begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = AW'(ra_last);
                        n_state     = ST_RA_SWAP;
                    end
                end else if (XW'(r_ptr) + XW'(1) + XW'(r_removed) < XW'(r_count)) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_ptr + AW'(1);
                    n_ptr       = r_ptr + AW'(1);
                end else begin
                    n_count = r_count - r_removed;
                    n_state = ST_DONE;
                end
            end

            // swapped-in element is written back and checked again from the held read data
            ST_RA_SWAP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr;
                o_mem_wdata = i_mem_rdata;
                n_state     = ST_RA_CMP;
            end

            // move element r_ptr up by one, read the one below
            ST_INS_SH: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr + AW'(1);
                o_mem_wdata = i_mem_rdata;
                if (XW'(r_ptr) == XW'(r_pos)) begin
                    n_state = ST_INS_PUT;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_ptr - AW'(1);
                    n_ptr       = r_ptr - AW'(1);
                end
            end

            ST_INS_PUT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(r_pos);
                o_mem_wdata = r_value;
                n_count     = r_count + CW'(1);
                n_ok        = 1'b1;
                n_state     = ST_DONE;
            end

            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_removed <= n_removed;
        r_ptr     <= n_ptr;
        r_fpos    <= n_fpos;
        r_found   <= n_found;
        r_ok      <= n_ok;
        r_mode    <= n_mode;
        r_value   <= n_value;
        r_pos     <= n_pos;
    end

    assign o_res.ok             = r_ok;
    assign o_res.found          = r_found;
    assign o_res.found_position = POS_W'(r_fpos);
    assign o_res.element_count  = COUNT_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= XW'(CAPACITY))
        else $error("fill count above capacity");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_we && o_mem_re && (o_mem_waddr == o_mem_raddr)))
        else $error("read and write of the same entry in one cycle");

    a_swap_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RA_SWAP) |-> $past(o_mem_re))
        else $error("swap without a read of the last element");

    a_shift_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS_SH) |-> $past(o_mem_re))
        else $error("shift write without read data");

endmodule

// ===== src/sequential_list_engine.sv =====
// top level of the fixed-capacity list engine with stream ports
//
//  channel   dir   handshake                      payload
//  s_axis    in    s_axis_tvalid/s_axis_tready    tuser: mode, tdata: value, position_in
//  m_axis    out   m_axis_tvalid/m_axis_tready    tuser: ok, found, tdata: position, count
//
//  append, clear and unknown modes finish without a memory walk
//  search reads elements in order to the first hit; remove then moves the last one into it
//  insert shifts elements p..count-1 up one slot; remove all refills each hit from the end
//  the single read port of the element memory limits each walk to at most one element a cycle
//  reset clears the fill count and state, the memory is not cleared and needs no sweep
//  a result waiting on m_axis does not block the next request from being taken
`timescale 1ns / 1ps

module sequential_list_engine
    import sle_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], position_in[39:32]
    input  logic [2:0]  s_axis_tuser,   // mode[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // found_position[7:0], element_count[16:8], zero pad
    output logic [1:0]  m_axis_tuser    // ok[0], found[1]
);

    localparam int AW = $clog2(CAPACITY);

    // memory access between sequencer and store
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    // finished result and output register
    t_result res;
    logic    res_valid;
    logic    res_take;
    t_result r_out;
    logic    r_out_valid;

    sle_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .i_value     (s_axis_tdata[31:0]),
        .i_pos       (s_axis_tdata[39:32]),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    sle_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output register takes a result when empty or when its transfer completes
    assign res_take = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.element_count, r_out.found_position};
    assign m_axis_tuser  = {r_out.found, r_out.ok};

endmodule
